// File: rtl/assert_macros.svh
// Assertion macros for the key/value table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at each rising edge, skipped while reset is high.
`define KVT_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("key_value_table check failed");

// Same, with a caller message.
`define KVT_CHECK_MSG(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`else

`define KVT_CHECK(label, clk, rst, prop)
`define KVT_CHECK_MSG(label, clk, rst, prop, msg)

`endif

`endif

// File: rtl/kvt_pkg.sv
// Shared types and constants of the key/value table.
package kvt_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FIELD_W = 32;
  localparam int COUNT_W = 7;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;
  localparam op_t OP_UPDATE = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } kvt_state_t;

endpackage

// File: rtl/key_value_table.sv
// Top level of the key/value table: scan controller, stores and result register.
//
//  channel | handshake            | fields                                 | direction
//  --------+----------------------+----------------------------------------+-------------
//  in      | in_valid, in_ready   | op, key, value                         | into block
//  out     | out_valid, out_ready | status, found, read_value, entry_count | out of block
//
// From one accept to the next, an item passes a scan of n entries, n being the entries
// compared (up to the first hit, at most DEPTH; none for clear or an empty table), in
// which the key store is read one entry per cycle, then the resolve step and idle.
// The result register is loaded in the resolve step.
// A result waiting on out_ready holds the controller in its resolve step; no new item
// is taken until the result is loaded. Reset empties the table; stores need no clearing.
module key_value_table
  import kvt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [FIELD_W-1:0] key,
  input  logic [FIELD_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               found,
  output logic [FIELD_W-1:0] read_value,
  output logic [COUNT_W-1:0] entry_count
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;

  kvt_state_t state, state_next;

  logic [CW-1:0]         fill, fill_next;
  op_t                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  hit;
  logic [AW-1:0]         cur;

  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  key_we, val_we;
  logic [AW-1:0]         val_waddr;

  logic                  in_acc, out_free, match, last;
  logic                  res_load;
  status_t               res_status;
  logic                  res_found;
  logic [FIELD_W-1:0]    res_value;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign match    = (key_rdata == key_q);
  assign last     = (CW'(cur) == fill - CW'(1));

  kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (fill[AW-1:0]),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_q),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_CLEAR || fill == '0) begin
            state_next = S_RESOLVE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match || last) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controls and result
  always_comb begin
    in_ready   = 1'b0;
    rd_addr    = cur + AW'(1);
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = cur;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_value  = '0;
    fill_next  = fill;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
      end
      S_SCAN: begin
      end
      S_RESOLVE: begin
        res_load = out_free;
        case (op_q)
          OP_CLEAR: begin
            fill_next = '0;
          end
          OP_INSERT: begin
            if (hit) begin
              res_status = ST_DUPLICATE;
              res_found  = 1'b1;
            end else if (fill == CW'(DEPTH)) begin
              res_status = ST_FULL;
            end else begin
              key_we    = out_free;
              val_we    = out_free;
              val_waddr = fill[AW-1:0];
              fill_next = fill + CW'(1);
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              res_found = 1'b1;
              res_value = FIELD_W'(hit_value[VW-1:0]);
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          default: begin
            if (hit) begin
              res_found = 1'b1;
              val_we    = out_free;
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q    <= op;
      key_q   <= KEY_BITS'(key[KW-1:0]);
      value_q <= VALUE_BITS'(value[VW-1:0]);
      hit     <= 1'b0;
      cur     <= '0;
    end else if (state == S_SCAN) begin
      if (match) begin
        hit       <= 1'b1;
        hit_value <= val_rdata;
      end else if (!last) begin
        cur <= cur + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= res_status;
      found       <= res_found;
      read_value  <= res_value;
      entry_count <= COUNT_W'(fill_next);
    end
  end

  `KVT_CHECK_MSG(a_fill_bound, clk, rst, fill <= CW'(DEPTH), "fill count above depth")
  `KVT_CHECK(a_result_from_resolve, clk, rst, $rose(out_valid) |-> $past(state) == S_RESOLVE)
  `KVT_CHECK(a_key_write_insert, clk, rst,
             key_we |-> (state == S_RESOLVE && op_q == OP_INSERT && !hit))
  `KVT_CHECK(a_accept_leaves_idle, clk, rst, in_acc |=> state != S_IDLE)

endmodule

// File: rtl/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
